FILE: design/cnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
package cnw_pkg;

  // Operation codes carried by an input beat
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYTE_SETTLE   = 2'd0;
  localparam logic [1:0] CFG_LONG_COMMAND  = 2'd1;
  localparam logic [1:0] CFG_INIT_WAIT     = 2'd2;

  // Register reset values (microseconds)
  localparam logic [11:0] BYTE_SETTLE_RST  = 12'd70;
  localparam logic [15:0] LONG_COMMAND_RST = 16'd2100;
  localparam logic [11:0] INIT_WAIT_RST    = 12'd199;

  // Display commands and wake-up nibble
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;

  // Widths
  localparam int unsigned HOLD_W = 17;
  localparam int unsigned CFG_W  = 16;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Result steps of the byte and init sequences
  localparam logic [2:0] STEP_FIRST     = 3'd0;
  localparam logic [2:0] STEP_BYTE_LAST = 3'd1;
  localparam logic [2:0] STEP_INIT_LAST = 3'd6;

  // Classified item passed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic       long_cmd;
    logic [7:0] value;
  } cnw_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } cnw_qstat_t;

endpackage

FILE: design/cnw_front.sv
// Front end: accepts request beats and classifies them for the queue.
module cnw_front (
  input  logic                  start_i,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            value_i,
  input  cnw_pkg::cnw_qstat_t   qstat_i,
  output logic                  busy_o,
  output logic                  push_o,
  output cnw_pkg::cnw_item_t    item_o
);
  import cnw_pkg::*;

  logic accept;
  logic known_op;

  // Hold off new beats while the queue is full
  assign busy_o = qstat_i.full;
  assign accept = start_i & ~qstat_i.full;

  // Drop the unused opcode: accepted, but nothing queued
  always_comb begin
    case (opcode_i)
      OP_DATA, OP_CMD, OP_INIT: known_op = 1'b1;
      default:                  known_op = 1'b0;
    endcase
  end

  assign push_o = accept & known_op;

  // Classify the beat
  always_comb begin
    item_o.is_init  = (opcode_i == OP_INIT);
    item_o.rs       = (opcode_i == OP_DATA);
    item_o.long_cmd = (opcode_i == OP_CMD) &&
                      ((value_i == CMD_CLEAR) || (value_i == CMD_HOME));
    item_o.value    = value_i;
  end

endmodule

FILE: design/cnw_queue.sv
// Two-entry queue that decouples the front end from the pulse sequencer.
module cnw_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cnw_pkg::cnw_item_t    item_i,
  input  logic                  pop_i,
  output cnw_pkg::cnw_item_t    item_o,
  output cnw_pkg::cnw_qstat_t   qstat_o
);
  import cnw_pkg::*;

  cnw_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign qstat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign item_o        = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != QCNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

FILE: design/cnw_back.sv
// Back end: steps through the pulses of each queued item, one result per cycle.
module cnw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cnw_pkg::cnw_qstat_t   qstat_i,
  input  cnw_pkg::cnw_item_t    item_i,
  input  logic [11:0]           byte_settle_us_i,
  input  logic [15:0]           long_command_us_i,
  input  logic [11:0]           init_wait_us_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output logic                  strobe_res_o,
  output logic                  reg_select_o,
  output logic [3:0]            nibble_o,
  output logic [cnw_pkg::HOLD_W-1:0] hold_us_o,
  output logic                  last_o
);
  import cnw_pkg::*;

  cnw_item_t          cur_q, cur_d;
  logic               active_q, active_d;
  logic [2:0]         step_q, step_d;
  logic               at_last;

  logic               valid_q, valid_d;
  logic               strobe_q, strobe_d;
  logic               rs_q, rs_d;
  logic [3:0]         nib_q, nib_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic               last_q, last_d;

  logic [HOLD_W-1:0]  settle_ext, wait_ext, byte_hold, init_hold;

  assign settle_ext = HOLD_W'(byte_settle_us_i);
  assign wait_ext   = HOLD_W'(init_wait_us_i);
  assign byte_hold  = cur_q.long_cmd ? settle_ext + HOLD_W'(long_command_us_i) : settle_ext;
  assign init_hold  = settle_ext + wait_ext;

  assign at_last = active_q &&
                   (cur_q.is_init ? (step_q == STEP_INIT_LAST) : (step_q == STEP_BYTE_LAST));

  // Pop the next item when idle or on the final pulse of the current one
  assign pop_o = !qstat_i.empty && (!active_q || at_last);

  // Build the result for the current step
  always_comb begin
    strobe_d = 1'b1;
    rs_d     = 1'b0;
    nib_d    = '0;
    hold_d   = '0;
    last_d   = at_last;
    if (cur_q.is_init) begin
      case (step_q)
        3'd0: begin
          strobe_d = 1'b0;
          hold_d   = wait_ext;
        end
        3'd1, 3'd3: nib_d = WAKE_NIBBLE;
        3'd2: begin
          nib_d  = WAKE_NIBBLE;
          hold_d = wait_ext;
        end
        3'd4: begin
          nib_d  = CMD_FUNC_4BIT[7:4];
          hold_d = wait_ext;
        end
        3'd5: nib_d = CMD_FUNC_4BIT[7:4];
        3'd6: begin
          nib_d  = CMD_FUNC_4BIT[3:0];
          hold_d = init_hold;
        end
        default: nib_d = '0;
      endcase
    end else begin
      rs_d = cur_q.rs;
      if (step_q == STEP_FIRST) begin
        nib_d = cur_q.value[7:4];
      end else begin
        nib_d  = cur_q.value[3:0];
        hold_d = byte_hold;
      end
    end
    valid_d = active_q;
  end

  // Advance the step counter and load the next item
  always_comb begin
    cur_d    = cur_q;
    active_d = active_q;
    step_d   = step_q;
    if (active_q && !at_last) begin
      step_d = step_q + 1'b1;
    end else if (pop_o) begin
      cur_d    = item_i;
      active_d = 1'b1;
      step_d   = STEP_FIRST;
    end else begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= STEP_FIRST;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      valid_q  <= valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    strobe_q <= strobe_d;
    rs_q     <= rs_d;
    nib_q    <= nib_d;
    hold_q   <= hold_d;
    last_q   <= last_d;
  end

  assign res_valid_o  = valid_q;
  assign strobe_res_o = strobe_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign hold_us_o    = hold_q;
  assign last_o       = last_q;

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (at_last && qstat_i.empty) |=> !active_q)
    else $error("sequencer stayed active after final pulse");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !cur_q.is_init) |-> (step_q <= STEP_BYTE_LAST))
    else $error("byte item stepped past its low nibble");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |=> res_valid_o)
    else $error("active step produced no result");

endmodule

FILE: design/char_lcd_nibble_writer.sv
// Top level of the character LCD nibble writer: config registers and front/queue/back.
//
// Usage:
//   Request channel: drive opcode_i (0 data byte, 1 command byte, 2 init) and
//   value_i with start_i high; the beat is taken at an edge where busy_o is low.
//   Opcode 3 is taken and dropped. busy_o rises only while the two-entry queue
//   is full.
//   Result channel: res_valid_o is high for exactly one cycle per result;
//   strobe_res_o, reg_select_o, nibble_o, hold_us_o and last_o are valid then.
//   The receiver cannot stall; every result appears once.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 byte settle,
//   1 long command, 2 init wait); index 3 is ignored. Write only when idle.
// Flow:
//   The request beat is registered in the queue, the sequencer loads it into its
//   item register, and each result leaves through the result registers. The
//   sequencer emits one result per cycle while it holds an item; queued items
//   follow with no gap. Sustained rate is set by the sequencer's step counter.
// Reset: rst_ni clears the queue and sequencer and loads the register defaults.
module char_lcd_nibble_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 value_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [cnw_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                       res_valid_o,
  output logic                       strobe_res_o,
  output logic                       reg_select_o,
  output logic [3:0]                 nibble_o,
  output logic [cnw_pkg::HOLD_W-1:0] hold_us_o,
  output logic                       last_o
);
  import cnw_pkg::*;

  logic [11:0] byte_settle_q;
  logic [15:0] long_command_q;
  logic [11:0] init_wait_q;

  logic        push;
  logic        pop;
  cnw_item_t   front_item;
  cnw_item_t   queue_item;
  cnw_qstat_t  qstat;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_settle_q  <= BYTE_SETTLE_RST;
      long_command_q <= LONG_COMMAND_RST;
      init_wait_q    <= INIT_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYTE_SETTLE:  byte_settle_q  <= cfg_data_i[11:0];
        CFG_LONG_COMMAND: long_command_q <= cfg_data_i[15:0];
        CFG_INIT_WAIT:    init_wait_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  cnw_front u_front (
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .value_i  (value_i),
    .qstat_i  (qstat),
    .busy_o   (busy_o),
    .push_o   (push),
    .item_o   (front_item)
  );

  cnw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .qstat_o (qstat)
  );

  cnw_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .qstat_i           (qstat),
    .item_i            (queue_item),
    .byte_settle_us_i  (byte_settle_q),
    .long_command_us_i (long_command_q),
    .init_wait_us_i    (init_wait_q),
    .pop_o             (pop),
    .res_valid_o       (res_valid_o),
    .strobe_res_o      (strobe_res_o),
    .reg_select_o      (reg_select_o),
    .nibble_o          (nibble_o),
    .hold_us_o         (hold_us_o),
    .last_o            (last_o)
  );

endmodule

FILE: bench/cnw_pulse_check.sv
// Result checker for the LCD nibble writer: predicts every pulse and compares it.
module cnw_pulse_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 value_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [cnw_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       res_valid_i,
  input  logic                       strobe_res_i,
  input  logic                       reg_select_i,
  input  logic [3:0]                 nibble_i,
  input  logic [cnw_pkg::HOLD_W-1:0] hold_us_i,
  input  logic                       last_i,
  output int                         fail_count_o,
  output int                         owed_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cnw_pkg::*;

  // One enable pulse, or a bare wait, as it leaves the block
  typedef struct packed {
    logic              strobe;
    logic              rs;
    logic [3:0]        nib;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } lcd_pulse_t;

  // Shadow copy of the timing registers
  logic [11:0] settle_us;
  logic [15:0] long_us;
  logic [11:0] wake_wait_us;

  // Pulses predicted but not yet seen, oldest first
  lcd_pulse_t pulses_due[$];

  function automatic lcd_pulse_t mk_pulse(input logic strobe, input logic rs,
                                          input logic [3:0] nib,
                                          input logic [HOLD_W-1:0] hold,
                                          input logic last);
    lcd_pulse_t p;
    p.strobe = strobe;
    p.rs     = rs;
    p.nib    = nib;
    p.hold   = hold;
    p.last   = last;
    return p;
  endfunction

  // Expand one accepted request into the pulses it should produce
  task automatic predict_pulses(input logic [1:0] op, input logic [7:0] val);
    logic [HOLD_W-1:0] tail_hold;
    logic [HOLD_W-1:0] wake_hold;
    logic              rs;
    wake_hold = HOLD_W'(wake_wait_us);
    case (op)
      OP_DATA, OP_CMD: begin
        rs = (op == OP_DATA);
        tail_hold = HOLD_W'(settle_us);
        // clear and home need the long extra wait, but only as commands
        if (op == OP_CMD && (val == CMD_CLEAR || val == CMD_HOME))
          tail_hold = tail_hold + HOLD_W'(long_us);
        pulses_due.push_back(mk_pulse(1'b1, rs, val[7:4], '0, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, rs, val[3:0], tail_hold, 1'b1));
      end
      OP_INIT: begin
        pulses_due.push_back(mk_pulse(1'b0, 1'b0, 4'h0, wake_hold, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, WAKE_NIBBLE, '0, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, WAKE_NIBBLE, wake_hold, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, WAKE_NIBBLE, '0, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, CMD_FUNC_4BIT[7:4], wake_hold, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, CMD_FUNC_4BIT[7:4], '0, 1'b0));
        pulses_due.push_back(mk_pulse(1'b1, 1'b0, CMD_FUNC_4BIT[3:0],
                                      HOLD_W'(settle_us) + wake_hold, 1'b1));
      end
      default: ; // unused opcode: dropped without a trace
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Watch both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lcd_pulse_t want;
    if (!rst_ni) begin
      settle_us    = BYTE_SETTLE_RST;
      long_us      = LONG_COMMAND_RST;
      wake_wait_us = INIT_WAIT_RST;
      pulses_due.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // compare the beat on the result port with the oldest prediction
      if (res_valid_i) begin
        if (pulses_due.size() == 0) begin
          $error("result beat with nothing expected: nibble %0d hold %0d",
                 nibble_i, hold_us_i);
          fail_count_o++;
        end else begin
          want = pulses_due.pop_front();
          check_field("strobe_res", want.strobe, strobe_res_i);
          check_field("reg_select", want.rs, reg_select_i);
          check_field("nibble", want.nib, nibble_i);
          check_field("hold_us", want.hold, hold_us_i);
          check_field("last", want.last, last_i);
          checked_o++;
        end
      end
      // track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BYTE_SETTLE:  settle_us    = cfg_data_i[11:0];
          CFG_LONG_COMMAND: long_us      = cfg_data_i[15:0];
          CFG_INIT_WAIT:    wake_wait_us = cfg_data_i[11:0];
          default: ;
        endcase
      end
      // predict for each request beat taken
      if (start_i && !busy_i)
        predict_pulses(opcode_i, value_i);
    end
    owed_o = pulses_due.size();
  end

endmodule

FILE: bench/char_lcd_nibble_writer_test.sv
// Stimulus and verdict for the LCD nibble writer; checking sits in cnw_pulse_check.
module char_lcd_nibble_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cnw_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 80;
  localparam int         TAIL_CYCLES = 8;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic [1:0]        opcode_i   = '0;
  logic [7:0]        value_i    = '0;
  logic              cfg_we_i   = 1'b0;
  logic [1:0]        cfg_idx_i  = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              busy_o;
  logic              res_valid_o;
  logic              strobe_res_o;
  logic              reg_select_o;
  logic [3:0]        nibble_o;
  logic [HOLD_W-1:0] hold_us_o;
  logic              last_o;

  int fails;
  int owed;
  int checked;
  int cycles = 0;
  int n_data = 0, n_cmd = 0, n_long = 0, n_init = 0, n_dropped = 0, n_settings = 1;

  always #6 clk_i = ~clk_i;

  char_lcd_nibble_writer uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_valid_o, .strobe_res_o, .reg_select_o, .nibble_o, .hold_us_o, .last_o
  );

  cnw_pulse_check watch (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .opcode_i, .value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_valid_i(res_valid_o), .strobe_res_i(strobe_res_o),
    .reg_select_i(reg_select_o), .nibble_i(nibble_o), .hold_us_i(hold_us_o),
    .last_i(last_o),
    .fail_count_o(fails), .owed_o(owed), .checked_o(checked)
  );

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request beat and hold it until taken; returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [7:0] val);
    start_i  <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    case (op)
      OP_DATA: n_data++;
      OP_CMD: begin
        n_cmd++;
        if (val == CMD_CLEAR || val == CMD_HOME) n_long++;
      end
      OP_INIT: n_init++;
      default: n_dropped++;
    endcase
  endtask

  // Drop start for a burst, with noise on the idle request lines
  task automatic pause(input int n);
    start_i  <= 1'b0;
    opcode_i <= 2'($urandom);
    value_i  <= 8'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  // Hold off until every predicted beat has come out, then let the pipe empty
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (owed != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Load all three timing registers, one per cycle, and optionally write the unused index
  task automatic set_regs(input logic [CFG_W-1:0] settle, input logic [CFG_W-1:0] lng,
                          input logic [CFG_W-1:0] wake, input bit poke_unused);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BYTE_SETTLE;
    cfg_data_i <= settle;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_LONG_COMMAND;
    cfg_data_i <= lng;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_INIT_WAIT;
    cfg_data_i <= wake;
    @(negedge clk_i);
    if (poke_unused) begin
      cfg_idx_i  <= CFG_UNUSED;
      cfg_data_i <= CFG_W'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly bytes, with clear/home commands boosted, some init runs and a few dropped
  task automatic random_item(output bit counted);
    int         pick;
    logic [1:0] op;
    logic [7:0] val;
    pick = $urandom_range(0, 99);
    val  = 8'($urandom);
    if (pick < 40) op = OP_DATA;
    else if (pick < 80) begin
      op = OP_CMD;
      if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
    end else if (pick < 92) op = OP_INIT;
    else op = OP_NONE;
    send_item(op, val);
    counted = (op != OP_NONE);
  endtask

  initial begin
    int real_items;
    bit counted;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset timings, back to back to fill the queue
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, CMD_CLEAR);
    send_item(OP_DATA, CMD_HOME);
    send_item(OP_CMD, CMD_CLEAR);
    send_item(OP_CMD, CMD_HOME);
    send_item(OP_CMD, 8'h00);
    send_item(OP_CMD, 8'hFF);
    send_item(OP_CMD, CMD_FUNC_4BIT);
    send_item(OP_CMD, 8'h03);
    send_item(OP_INIT, 8'h00);
    send_item(OP_NONE, 8'hA5);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_INIT, 8'hFF);
    send_item(OP_CMD, CMD_CLEAR);
    pause(3);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_NONE, 8'h5A);
    send_item(OP_CMD, CMD_HOME);
    send_item(OP_DATA, 8'h80);
    send_item(OP_CMD, 8'h0F);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs('0, '0, '0, 1'b0);
        1: set_regs('1, '1, '1, 1'b1);
        3: set_regs(CFG_W'(BYTE_SETTLE_RST), LONG_COMMAND_RST, CFG_W'(INIT_WAIT_RST), 1'b0);
        default: set_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), ph == 4);
      endcase
      real_items = 0;
      while (real_items < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) real_items++;
        // the last phase runs with no gaps at all
        if (ph != PHASES - 1) begin
          if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 11));
          else if ($urandom_range(0, 59) == 0) drain();
        end
      end
      drain();
    end

    $display("sent %0d data bytes, %0d commands (%0d clear/home), %0d init runs, %0d dropped",
             n_data, n_cmd, n_long, n_init, n_dropped);
    $display("over %0d register settings; %0d result beats compared", n_settings, checked);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
